// ===== rtl/core/rti_pkg.sv =====
// shared constants and types for the ray/triangle intersection block
// no dependencies
`timescale 1ns / 1ps

package rti_pkg;

    localparam int FIELD_W = 16;
    localparam int REG_W   = 48;
    localparam int DIST_W  = 32;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_PLANE = 2'd2;

    localparam logic [1:0] REG_VTX_A = 2'd0;
    localparam logic [1:0] REG_VTX_B = 2'd1;
    localparam logic [1:0] REG_VTX_C = 2'd2;

    localparam logic [1:0] SETUP_LAT = 2'd3;

    typedef struct packed {
        logic       vld;
        logic [1:0] status;
        logic       sat;
    } t_ctl;

endpackage

// ===== rtl/core/rti_if.sv =====
// ray and result channel interfaces
// depends on rti_pkg
`timescale 1ns / 1ps

interface rti_ray_if;
    logic                                valid;
    logic                                ready;
    logic signed [rti_pkg::FIELD_W-1:0]  origin_x;
    logic signed [rti_pkg::FIELD_W-1:0]  origin_y;
    logic signed [rti_pkg::FIELD_W-1:0]  origin_z;
    logic signed [rti_pkg::FIELD_W-1:0]  dir_x;
    logic signed [rti_pkg::FIELD_W-1:0]  dir_y;
    logic signed [rti_pkg::FIELD_W-1:0]  dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rti_res_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [rti_pkg::DIST_W-1:0]   distance;

    modport source (output valid, status, distance, input ready);
    modport sink   (input valid, status, distance, output ready);
endinterface

// ===== rtl/core/rti_tri_setup.sv =====
// vertex registers, apb port and derived triangle state (edges, normal, offset)
// depends on rti_pkg
`timescale 1ns / 1ps

module rti_tri_setup #(
    parameter int CW = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rti_pkg::PADDR_W-1:0]  paddr,
    input  logic [rti_pkg::PDATA_W-1:0]  pwdata,
    output logic [rti_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic                         o_busy,
    output logic signed [CW-1:0]         o_av [3],
    output logic signed [CW:0]           o_e1 [3],
    output logic signed [CW:0]           o_e2 [3],
    output logic signed [2*CW+2:0]       o_n  [3],
    output logic signed [3*CW+5:0]       o_off
);
    import rti_pkg::*;

    localparam int EW = CW + 1;
    localparam int NW = 2 * CW + 3;
    localparam int SW = 3 * CW + 6;
    localparam int PW = CW + NW;

    logic [REG_W-1:0]       r_vtx [3];
    logic [1:0]             r_busy_cnt;
    logic signed [EW-1:0]   r_e1 [3];
    logic signed [EW-1:0]   r_e2 [3];
    logic signed [NW-1:0]   r_n  [3];
    logic signed [SW-1:0]   r_off;

    logic                   wr_en;
    logic [1:0]             idx;
    logic signed [CW-1:0]   vb [3];
    logic signed [CW-1:0]   vc [3];
    logic signed [2*EW-1:0] na [3];
    logic signed [2*EW-1:0] nb [3];
    logic signed [NW-1:0]   n_n [3];
    logic signed [PW-1:0]   ap [3];
    logic signed [SW-1:0]   n_off;

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_busy = (r_busy_cnt != 2'd0);

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_VTX_A: prdata = PDATA_W'(r_vtx[0]);
            REG_VTX_B: prdata = PDATA_W'(r_vtx[1]);
            REG_VTX_C: prdata = PDATA_W'(r_vtx[2]);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx[0]   <= '0;
            r_vtx[1]   <= '0;
            r_vtx[2]   <= '0;
            r_busy_cnt <= '0;
        end else begin
            if (wr_en) begin
                unique case (idx)
                    REG_VTX_A: r_vtx[0] <= pwdata[REG_W-1:0];
                    REG_VTX_B: r_vtx[1] <= pwdata[REG_W-1:0];
                    REG_VTX_C: r_vtx[2] <= pwdata[REG_W-1:0];
                    default:   ;
                endcase
            end
            if (wr_en)
                r_busy_cnt <= SETUP_LAT;
            else if (r_busy_cnt != 2'd0)
                r_busy_cnt <= r_busy_cnt - 2'd1;
        end
    end

    // x in the top field, z in the low field
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_av[k] = signed'(r_vtx[0][(2-k)*CW +: CW]);
            vb[k]   = signed'(r_vtx[1][(2-k)*CW +: CW]);
            vc[k]   = signed'(r_vtx[2][(2-k)*CW +: CW]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            na[k]  = r_e1[NXT[k]] * r_e2[PRV[k]];
            nb[k]  = r_e1[PRV[k]] * r_e2[NXT[k]];
            n_n[k] = NW'(na[k]) - NW'(nb[k]);
            ap[k]  = o_av[k] * r_n[k];
        end
        n_off = SW'(ap[0]) + SW'(ap[1]) + SW'(ap[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= '0;
                r_e2[k] <= '0;
                r_n[k]  <= '0;
            end
            r_off <= '0;
        end else begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= EW'(vb[k]) - EW'(o_av[k]);
                r_e2[k] <= EW'(vc[k]) - EW'(o_av[k]);
                r_n[k]  <= n_n[k];
            end
            r_off <= n_off;
        end
    end

    assign o_e1  = r_e1;
    assign o_e2  = r_e2;
    assign o_n   = r_n;
    assign o_off = r_off;

endmodule

// ===== rtl/core/rti_div_step.sv =====
// one restoring division step of the distance divider, registered
// depends on rti_pkg
`timescale 1ns / 1ps

module rti_div_step #(
    parameter int AW = 54
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  rti_pkg::t_ctl               i_ctl,
    input  logic [AW-1:0]               i_ad,
    input  logic [AW-1:0]               i_rem,
    input  logic [rti_pkg::DIST_W-1:0]  i_bits,
    output rti_pkg::t_ctl               o_ctl,
    output logic [AW-1:0]               o_ad,
    output logic [AW-1:0]               o_rem,
    output logic [rti_pkg::DIST_W-1:0]  o_bits
);
    import rti_pkg::*;

    t_ctl               r_ctl;
    logic [AW-1:0]      r_ad;
    logic [AW-1:0]      r_rem;
    logic [DIST_W-1:0]  r_bits;

    logic [AW:0]        t;
    logic [AW:0]        dif;
    logic               ge;
    logic [AW-1:0]      n_rem;
    logic [DIST_W-1:0]  n_bits;

    always_comb begin
        t      = {i_rem, i_bits[DIST_W-1]};
        dif    = t - {1'b0, i_ad};
        ge     = (t >= {1'b0, i_ad});
        n_rem  = ge ? dif[AW-1:0] : t[AW-1:0];
        n_bits = {i_bits[DIST_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ad   <= i_ad;
            r_rem  <= n_rem;
            r_bits <= n_bits;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_ad   = r_ad;
    assign o_rem  = r_rem;
    assign o_bits = r_bits;

endmodule

// ===== rtl/core/rti_geom.sv =====
// ray geometry pipeline: plane distance terms, barycentric test, divider setup
// depends on rti_pkg
`timescale 1ns / 1ps

module rti_geom #(
    parameter int CW = 16,
    parameter int DF = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_vld,
    input  logic signed [CW-1:0]        i_org [3],
    input  logic signed [CW-1:0]        i_dir [3],
    input  logic signed [CW-1:0]        i_av  [3],
    input  logic signed [CW:0]          i_e1  [3],
    input  logic signed [CW:0]          i_e2  [3],
    input  logic signed [2*CW+2:0]      i_n   [3],
    input  logic signed [3*CW+5:0]      i_off,
    output rti_pkg::t_ctl               o_ctl,
    output logic [3*CW+5:0]             o_ad,
    output logic [3*CW+5:0]             o_rem,
    output logic [rti_pkg::DIST_W-1:0]  o_bits
);
    import rti_pkg::*;

    localparam int EW  = CW + 1;
    localparam int NW  = 2 * CW + 3;
    localparam int PW  = 2 * CW + 2;
    localparam int SW  = 3 * CW + 6;
    localparam int AW  = SW;
    localparam int NXW = AW + DF;
    localparam int IW  = DIST_W - DF;
    localparam int CMW = AW + IW;

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

    // stage 1
    logic                   r1_vld;
    logic signed [CW-1:0]   r1_o  [3];
    logic signed [CW-1:0]   r1_d  [3];
    logic signed [EW-1:0]   r1_tv [3];
    // stage 2
    logic                   r2_vld;
    logic signed [CW-1:0]   r2_d  [3];
    logic signed [EW-1:0]   r2_tv [3];
    logic signed [PW-1:0]   r2_p  [3];
    logic signed [NW-1:0]   r2_q  [3];
    logic signed [SW-1:0]   r2_num;
    logic signed [SW-1:0]   r2_den;
    // stage 3
    logic                   r3_vld;
    logic signed [SW-1:0]   r3_num;
    logic signed [SW-1:0]   r3_den;
    logic signed [SW-1:0]   r3_sn;
    logic signed [SW-1:0]   r3_tn;
    // stage 4
    t_ctl                   r4_ctl;
    logic [AW-1:0]          r4_an;
    logic [AW-1:0]          r4_ad;
    // stage 5
    t_ctl                   r5_ctl;
    logic [AW-1:0]          r5_ad;
    logic [AW-1:0]          r5_rem;
    logic [DIST_W-1:0]      r5_bits;

    logic signed [EW-1:0]      n1_tv [3];
    logic signed [CW+EW-1:0]   pa [3];
    logic signed [CW+EW-1:0]   pb [3];
    logic signed [2*EW-1:0]    qa [3];
    logic signed [2*EW-1:0]    qb [3];
    logic signed [CW+NW-1:0]   on [3];
    logic signed [CW+NW-1:0]   dn [3];
    logic signed [PW-1:0]      n2_p [3];
    logic signed [NW-1:0]      n2_q [3];
    logic signed [SW-1:0]      n2_num;
    logic signed [SW-1:0]      n2_den;
    logic signed [EW+PW-1:0]   sp [3];
    logic signed [CW+NW-1:0]   tq [3];
    logic signed [SW-1:0]      n3_sn;
    logic signed [SW-1:0]      n3_tn;
    logic                      degen;
    logic signed [SW:0]        sx;
    logic signed [SW:0]        tx;
    logic signed [SW:0]        dabs;
    logic                      outside;
    t_ctl                      n4_ctl;
    logic [AW-1:0]             n4_an;
    logic [AW-1:0]             n4_ad;
    logic [NXW-1:0]            nx;
    t_ctl                      n5_ctl;

    always_comb begin
        for (int k = 0; k < 3; k++)
            n1_tv[k] = EW'(i_org[k]) - EW'(i_av[k]);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pa[k]   = r1_d[NXT[k]] * i_e2[PRV[k]];
            pb[k]   = r1_d[PRV[k]] * i_e2[NXT[k]];
            n2_p[k] = PW'(pa[k]) - PW'(pb[k]);
            qa[k]   = r1_tv[NXT[k]] * i_e1[PRV[k]];
            qb[k]   = r1_tv[PRV[k]] * i_e1[NXT[k]];
            n2_q[k] = NW'(qa[k]) - NW'(qb[k]);
            on[k]   = r1_o[k] * i_n[k];
            dn[k]   = r1_d[k] * i_n[k];
        end
        n2_num = i_off - SW'(on[0]) - SW'(on[1]) - SW'(on[2]);
        n2_den = SW'(dn[0]) + SW'(dn[1]) + SW'(dn[2]);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sp[k] = r2_tv[k] * r2_p[k];
            tq[k] = r2_d[k] * r2_q[k];
        end
        n3_sn = SW'(sp[0]) + SW'(sp[1]) + SW'(sp[2]);
        n3_tn = SW'(tq[0]) + SW'(tq[1]) + SW'(tq[2]);
    end

    // the cramer determinant equals minus the plane denominator
    always_comb begin
        degen = (i_n[0] == '0) && (i_n[1] == '0) && (i_n[2] == '0);
        if (r3_den > 0) begin
            sx = -(SW+1)'(r3_sn);
            tx = -(SW+1)'(r3_tn);
        end else begin
            sx = (SW+1)'(r3_sn);
            tx = (SW+1)'(r3_tn);
        end
        dabs    = r3_den[SW-1] ? -(SW+1)'(r3_den) : (SW+1)'(r3_den);
        outside = (sx < 0) || (tx < 0) || ((sx + tx) > dabs);
        n4_ctl.vld = r3_vld;
        n4_ctl.sat = 1'b0;
        if (degen)
            n4_ctl.status = ST_MISS;
        else if (r3_num == '0 && r3_den == '0)
            n4_ctl.status = ST_PLANE;
        else if (r3_num == '0 || r3_den == '0 || (r3_num[SW-1] != r3_den[SW-1]))
            n4_ctl.status = ST_MISS;
        else if (outside)
            n4_ctl.status = ST_MISS;
        else
            n4_ctl.status = ST_HIT;
        n4_an = r3_num[SW-1] ? AW'(-r3_num) : AW'(r3_num);
        n4_ad = r3_den[SW-1] ? AW'(-r3_den) : AW'(r3_den);
    end

    always_comb begin
        nx         = {r4_an, DF'(0)};
        n5_ctl     = r4_ctl;
        n5_ctl.sat = (CMW'(r4_an) >= (CMW'(r4_ad) << IW));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_ctl <= '0;
            r5_ctl <= '0;
        end else if (i_adv) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_ctl <= n4_ctl;
            r5_ctl <= n5_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 3; k++) begin
                r1_o[k]  <= i_org[k];
                r1_d[k]  <= i_dir[k];
                r1_tv[k] <= n1_tv[k];
                r2_d[k]  <= r1_d[k];
                r2_tv[k] <= r1_tv[k];
                r2_p[k]  <= n2_p[k];
                r2_q[k]  <= n2_q[k];
            end
            r2_num  <= n2_num;
            r2_den  <= n2_den;
            r3_num  <= r2_num;
            r3_den  <= r2_den;
            r3_sn   <= n3_sn;
            r3_tn   <= n3_tn;
            r4_an   <= n4_an;
            r4_ad   <= n4_ad;
            r5_ad   <= r4_ad;
            r5_rem  <= AW'(nx[NXW-1:DIST_W]);
            r5_bits <= nx[DIST_W-1:0];
        end
    end

    assign o_ctl  = r5_ctl;
    assign o_ad   = r5_ad;
    assign o_rem  = r5_rem;
    assign o_bits = r5_bits;

endmodule

// ===== rtl/core/ray_triangle_intersect.sv =====
// top level of the ray/triangle intersection block
// depends on rti_pkg, rti_if, rti_tri_setup, rti_geom, rti_div_step
`timescale 1ns / 1ps

// Tests one ray per clock, while the ray input is not held off, against a triangle
// held in three APB vertex registers (byte addresses 0, 8, 16). Every ray item
// gives one result item: hit with the ray distance in unsigned fixed point
// (DIST_FRAC_BITS fraction bits, truncated, saturated to all ones), miss, or
// lies-in-plane. The pipeline has five geometry stages, one stage per quotient
// bit of the 32-bit distance divider, and the output register. The whole
// pipeline holds while a result waits to be taken. After a vertex write the
// ray input is held off while the edges, normal and plane offset are rebuilt.
module ray_triangle_intersect #(
    parameter int COORD_BITS     = 16,
    parameter int DIST_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    rti_ray_if.sink                      i_ray,
    rti_res_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rti_pkg::PADDR_W-1:0]  paddr,
    input  logic [rti_pkg::PDATA_W-1:0]  pwdata,
    output logic [rti_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import rti_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int AW = 3 * CW + 6;

    logic                    busy;
    logic                    adv;
    logic                    in_vld;
    logic signed [CW-1:0]    av  [3];
    logic signed [CW:0]      e1  [3];
    logic signed [CW:0]      e2  [3];
    logic signed [2*CW+2:0]  nrm [3];
    logic signed [AW-1:0]    off;
    logic signed [CW-1:0]    org [3];
    logic signed [CW-1:0]    dir [3];

    t_ctl                    c_ctl  [DIST_W+1];
    logic [AW-1:0]           c_ad   [DIST_W+1];
    logic [AW-1:0]           c_rem  [DIST_W+1];
    logic [DIST_W-1:0]       c_bits [DIST_W+1];

    logic                    r_out_vld;
    logic [1:0]              r_status;
    logic [DIST_W-1:0]       r_dist;
    t_ctl                    last;
    logic [DIST_W-1:0]       n_dist;

    assign adv         = !r_out_vld || o_res.ready;
    assign i_ray.ready = adv && !busy;
    assign in_vld      = i_ray.valid && i_ray.ready;

    assign org[0] = signed'(i_ray.origin_x[CW-1:0]);
    assign org[1] = signed'(i_ray.origin_y[CW-1:0]);
    assign org[2] = signed'(i_ray.origin_z[CW-1:0]);
    assign dir[0] = signed'(i_ray.dir_x[CW-1:0]);
    assign dir[1] = signed'(i_ray.dir_y[CW-1:0]);
    assign dir[2] = signed'(i_ray.dir_z[CW-1:0]);

    rti_tri_setup #(.CW(CW)) u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_busy  (busy),
        .o_av    (av),
        .o_e1    (e1),
        .o_e2    (e2),
        .o_n     (nrm),
        .o_off   (off)
    );

    rti_geom #(.CW(CW), .DF(DIST_FRAC_BITS)) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_vld   (in_vld),
        .i_org   (org),
        .i_dir   (dir),
        .i_av    (av),
        .i_e1    (e1),
        .i_e2    (e2),
        .i_n     (nrm),
        .i_off   (off),
        .o_ctl   (c_ctl[0]),
        .o_ad    (c_ad[0]),
        .o_rem   (c_rem[0]),
        .o_bits  (c_bits[0])
    );

    for (genvar g = 0; g < DIST_W; g++) begin : g_div
        rti_div_step #(.AW(AW)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_ctl   (c_ctl[g]),
            .i_ad    (c_ad[g]),
            .i_rem   (c_rem[g]),
            .i_bits  (c_bits[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_ad    (c_ad[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_bits  (c_bits[g+1])
        );
    end

    always_comb begin
        last = c_ctl[DIST_W];
        if (last.status != ST_HIT)
            n_dist = '0;
        else if (last.sat)
            n_dist = '1;
        else
            n_dist = c_bits[DIST_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_status <= last.status;
            r_dist   <= n_dist;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.status   = r_status;
    assign o_res.distance = r_dist;

endmodule
